// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; define ASSERT_OFF to drop them all.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

// ----- rtl/toeq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package toeq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;

  // Field widths
  localparam int MODE_W      = 1;
  localparam int STAMP_W     = 64;
  localparam int SEQ_W       = 32;
  localparam int EVENT_TAG_W = 16;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;

  // Tag bits actually kept in a slot
  localparam int TAG_KEEP = (TAG_BITS < EVENT_TAG_W) ? TAG_BITS : EVENT_TAG_W;
  // Fill counter must hold the depth itself
  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the input beat
  localparam logic [MODE_W-1:0] MODE_PUSH = 1'b0;
  localparam logic [MODE_W-1:0] MODE_POP  = 1'b1;

  // Status codes on the output beat
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [STAMP_W-1:0]     stamp;
    logic [SEQ_W-1:0]       seq_key;
    logic [EVENT_TAG_W-1:0] event_tag;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   popped_valid;
    logic [EVENT_TAG_W-1:0] popped_tag;
    logic [STAMP_W-1:0]     popped_stamp;
    logic [SEQ_W-1:0]       popped_seq;
    logic [EVENT_TAG_W-1:0] head_tag;
    logic [STAMP_W-1:0]     head_stamp;
    logic                   is_empty;
    logic [OCC_W-1:0]       occupancy;
  } out_item_t;

  // Datapath operation chosen by the controller
  typedef enum logic [1:0] {
    OP_INSERT       = 2'd0,
    OP_REMOVE       = 2'd1,
    OP_REJECT_FULL  = 2'd2,
    OP_REJECT_EMPTY = 2'd3
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    op_t  op;
  } toeq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop;
    logic full;
    logic empty;
  } toeq_stat_t;

endpackage

`default_nettype wire

// ----- rtl/timestamp_ordered_event_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stable sorted event queue of QUEUE_DEPTH entries, ordered by stamp and then
// seq_key; entries with equal keys leave in arrival order. Each input beat
// (push or pop) yields exactly one output beat with the status, any popped
// entry, the head after the operation, an empty flag and the count. A push
// into a full queue is refused with a full status and a pop on an empty queue
// with an empty status; neither changes the contents. An item is first
// accepted into a holding register; once the output register is free, every
// slot compares its key against the new one and shifts in parallel. The next
// beat is accepted in the cycle after that, while the previous result may
// still wait in the output register; no new beat is taken before the last
// one has run. The slots start empty after reset with no clearing pass.
module timestamp_ordered_event_queue
  import toeq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  toeq_cmd_t  cmd;
  toeq_stat_t stat;

  toeq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  toeq_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/toeq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module toeq_ctrl
  import toeq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  toeq_stat_t stat,
  output toeq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  // Sequence: take a beat, then run it once the output register is free
  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid;
    if (stat.pop) begin
      cmd.op = stat.empty ? OP_REJECT_EMPTY : OP_REMOVE;
    end else begin
      cmd.op = stat.full ? OP_REJECT_FULL : OP_INSERT;
    end
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLY(a_exec_slot_free, clk, rst, cmd.exec, !out_valid || out_ready)
  `ASSERT_NEXT(a_exec_shows_beat, clk, rst, cmd.exec, out_valid)
  `ASSERT_IMPLY(a_no_insert_full, clk, rst, cmd.exec && cmd.op == OP_INSERT, !stat.full)

endmodule

`default_nettype wire

// ----- rtl/toeq_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module toeq_dpath
  import toeq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_data,
  input  toeq_cmd_t  cmd,
  output toeq_stat_t stat,
  output out_item_t  out_data
);

  in_item_t             pend;
  logic [STAMP_W-1:0]   slot_stamp [QUEUE_DEPTH];
  logic [SEQ_W-1:0]     slot_seq   [QUEUE_DEPTH];
  logic [TAG_KEEP-1:0]  slot_tag   [QUEUE_DEPTH];
  logic [FILL_W-1:0]    fill, fill_next;
  out_item_t            out_reg, out_next;

  logic [QUEUE_DEPTH-1:0] le;
  logic [QUEUE_DEPTH-1:0] prev_le;
  logic [STAMP_W-1:0]     lo_stamp [QUEUE_DEPTH];
  logic [SEQ_W-1:0]       lo_seq   [QUEUE_DEPTH];
  logic [TAG_KEEP-1:0]    lo_tag   [QUEUE_DEPTH];
  logic [STAMP_W-1:0]     hi_stamp [QUEUE_DEPTH];
  logic [SEQ_W-1:0]       hi_seq   [QUEUE_DEPTH];
  logic [TAG_KEEP-1:0]    hi_tag   [QUEUE_DEPTH];
  logic                   head_in_order;

  assign stat.pop   = (pend.mode == MODE_POP);
  assign stat.full  = (fill == FILL_W'(QUEUE_DEPTH));
  assign stat.empty = (fill == '0);
  assign out_data   = out_reg;

  // First two slots in key order
  assign head_in_order = (slot_stamp[0] < slot_stamp[1]) ||
                         ((slot_stamp[0] == slot_stamp[1]) && (slot_seq[0] <= slot_seq[1]));

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pend <= in_data;
    end
  end

  // Each slot compares itself against the new key and picks its neighbor
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign le[i] = (FILL_W'(i) < fill) &&
                   ((slot_stamp[i] < pend.stamp) ||
                    ((slot_stamp[i] == pend.stamp) && (slot_seq[i] <= pend.seq_key)));
    if (i == 0) begin : g_first
      assign prev_le[i]  = 1'b1;
      assign lo_stamp[i] = pend.stamp;
      assign lo_seq[i]   = pend.seq_key;
      assign lo_tag[i]   = pend.event_tag[TAG_KEEP-1:0];
    end else begin : g_rest
      assign prev_le[i]  = le[i-1];
      assign lo_stamp[i] = slot_stamp[i-1];
      assign lo_seq[i]   = slot_seq[i-1];
      assign lo_tag[i]   = slot_tag[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign hi_stamp[i] = slot_stamp[i];
      assign hi_seq[i]   = slot_seq[i];
      assign hi_tag[i]   = slot_tag[i];
    end else begin : g_upper
      assign hi_stamp[i] = slot_stamp[i+1];
      assign hi_seq[i]   = slot_seq[i+1];
      assign hi_tag[i]   = slot_tag[i+1];
    end

    // Keep, take the new entry, shift back on insert; shift forward on remove
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        case (cmd.op)
          OP_INSERT: begin
            if (!le[i]) begin
              if (prev_le[i]) begin
                slot_stamp[i] <= pend.stamp;
                slot_seq[i]   <= pend.seq_key;
                slot_tag[i]   <= pend.event_tag[TAG_KEEP-1:0];
              end else begin
                slot_stamp[i] <= lo_stamp[i];
                slot_seq[i]   <= lo_seq[i];
                slot_tag[i]   <= lo_tag[i];
              end
            end
          end
          OP_REMOVE: begin
            slot_stamp[i] <= hi_stamp[i];
            slot_seq[i]   <= hi_seq[i];
            slot_tag[i]   <= hi_tag[i];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Work out the count and the result beat
  always_comb begin
    fill_next = fill;
    out_next  = '0;
    case (cmd.op)
      OP_INSERT: begin
        fill_next       = fill + FILL_W'(1);
        out_next.status = ST_OK;
        if (le[0]) begin
          out_next.head_tag   = EVENT_TAG_W'(slot_tag[0]);
          out_next.head_stamp = slot_stamp[0];
        end else begin
          out_next.head_tag   = EVENT_TAG_W'(pend.event_tag[TAG_KEEP-1:0]);
          out_next.head_stamp = pend.stamp;
        end
      end
      OP_REMOVE: begin
        fill_next             = fill - FILL_W'(1);
        out_next.status       = ST_OK;
        out_next.popped_valid = 1'b1;
        out_next.popped_tag   = EVENT_TAG_W'(slot_tag[0]);
        out_next.popped_stamp = slot_stamp[0];
        out_next.popped_seq   = slot_seq[0];
        if (fill > FILL_W'(1)) begin
          out_next.head_tag   = EVENT_TAG_W'(slot_tag[1]);
          out_next.head_stamp = slot_stamp[1];
        end
      end
      OP_REJECT_FULL: begin
        out_next.status     = ST_FULL;
        out_next.head_tag   = EVENT_TAG_W'(slot_tag[0]);
        out_next.head_stamp = slot_stamp[0];
      end
      OP_REJECT_EMPTY: begin
        out_next.status = ST_EMPTY;
      end
      default: begin
        out_next.status = ST_OK;
      end
    endcase
    out_next.is_empty  = (fill_next == '0);
    out_next.occupancy = OCC_W'(fill_next);
  end

  // Load the count on every executed beat; rejects leave it unchanged
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.exec) begin
      fill <= fill_next;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_reg <= out_next;
    end
  end

  `ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, fill <= FILL_W'(QUEUE_DEPTH))
  `ASSERT_IMPLY(a_head_order, clk, rst, fill >= FILL_W'(2), head_in_order)
  `ASSERT_NEXT(a_remove_count, clk, rst, cmd.exec && cmd.op == OP_REMOVE, fill == $past(fill) - FILL_W'(1))

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench
  import toeq_pkg::*;
;

  typedef struct {
    in_item_t beat;
    bit       drain_first;
  } send_slot_t;

  localparam logic [EVENT_TAG_W-1:0] TAG_MASK = (TAG_KEEP >= EVENT_TAG_W) ?
    {EVENT_TAG_W{1'b1}} : EVENT_TAG_W'((64'd1 << TAG_KEEP) - 64'd1);
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
  localparam logic [SEQ_W-1:0]   SEQ_MAX   = {SEQ_W{1'b1}};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // sorted copy of the queue contents, earliest entry at index 0
  logic [STAMP_W-1:0]     ord_stamp [QUEUE_DEPTH];
  logic [SEQ_W-1:0]       ord_seq   [QUEUE_DEPTH];
  logic [EVENT_TAG_W-1:0] ord_tag   [QUEUE_DEPTH];
  int                     ord_count = 0;

  send_slot_t beats_to_send [$];
  out_item_t  awaited_results [$];
  out_item_t  want;
  send_slot_t next_slot;
  int         mismatch_count = 0;
  int         send_idle = 0;
  int         recv_stall = 0;

  timestamp_ordered_event_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Apply one push or pop to the sorted copy and return the result beat
  function automatic out_item_t sorted_queue_step(input in_item_t b);
    out_item_t r;
    int        i;
    r = '0;
    r.status = ST_OK;
    if (b.mode == MODE_PUSH) begin
      if (ord_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // open a gap behind every entry that is earlier or equal
        i = ord_count;
        while (i > 0 && !((ord_stamp[i-1] < b.stamp) ||
                          (ord_stamp[i-1] == b.stamp && ord_seq[i-1] <= b.seq_key))) begin
          ord_stamp[i] = ord_stamp[i-1];
          ord_seq[i]   = ord_seq[i-1];
          ord_tag[i]   = ord_tag[i-1];
          i--;
        end
        ord_stamp[i] = b.stamp;
        ord_seq[i]   = b.seq_key;
        ord_tag[i]   = b.event_tag & TAG_MASK;
        ord_count++;
      end
    end else begin
      if (ord_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_valid = 1'b1;
        r.popped_tag   = ord_tag[0];
        r.popped_stamp = ord_stamp[0];
        r.popped_seq   = ord_seq[0];
        for (i = 1; i < ord_count; i++) begin
          ord_stamp[i-1] = ord_stamp[i];
          ord_seq[i-1]   = ord_seq[i];
          ord_tag[i-1]   = ord_tag[i];
        end
        ord_count--;
      end
    end
    r.is_empty = (ord_count == 0);
    if (ord_count > 0) begin
      r.head_tag   = ord_tag[0];
      r.head_stamp = ord_stamp[0];
    end
    r.occupancy = OCC_W'(ord_count);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Keys lean toward a few small values and the top of the range so ties are common
  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(9))
      0: return '0;
      1: return STAMP_MAX;
      2, 3, 4, 5: return STAMP_W'($urandom_range(3));
      6: return STAMP_MAX - STAMP_W'($urandom_range(3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [SEQ_W-1:0] pick_seq();
    case ($urandom_range(9))
      0: return '0;
      1: return SEQ_MAX;
      2, 3, 4, 5: return SEQ_W'($urandom_range(3));
      6: return SEQ_MAX - SEQ_W'($urandom_range(3));
      default: return SEQ_W'($urandom);
    endcase
  endfunction

  function automatic void add_beat(input logic [MODE_W-1:0] mode, input logic [STAMP_W-1:0] st,
                                   input logic [SEQ_W-1:0] sq, input logic [EVENT_TAG_W-1:0] tg,
                                   input bit drain);
    send_slot_t s;
    s.beat.mode      = mode;
    s.beat.stamp     = st;
    s.beat.seq_key   = sq;
    s.beat.event_tag = tg;
    s.drain_first    = drain;
    beats_to_send.push_back(s);
  endfunction

  // Bursts of pushes then pops drive the queue to full and back to empty; some noise between
  function automatic void add_random(input int n);
    int made;
    int npush;
    int npop;
    int k;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) == 0) begin
        add_beat(MODE_W'($urandom_range(1)), pick_stamp(), pick_seq(),
                 EVENT_TAG_W'($urandom), made == 0);
        made++;
      end else begin
        npush = $urandom_range(20);
        npop  = $urandom_range(20);
        for (k = 0; k < npush; k++)
          add_beat(MODE_PUSH, pick_stamp(), pick_seq(), EVENT_TAG_W'($urandom),
                   made == 0 && k == 0);
        for (k = 0; k < npop; k++)
          add_beat(MODE_POP, {$urandom, $urandom}, SEQ_W'($urandom), EVENT_TAG_W'($urandom),
                   made == 0 && npush == 0 && k == 0);
        made += npush + npop;
      end
    end
  endfunction

  // Drive input beats; predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        awaited_results.push_back(sorted_queue_step(in_data));
      if (!in_valid || in_ready) begin
        if (beats_to_send.size() > 0 &&
            !(beats_to_send[0].drain_first && awaited_results.size() > 0) &&
            $urandom_range(99) >= send_idle) begin
          next_slot = beats_to_send.pop_front();
          in_data  <= next_slot.beat;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each output beat against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("output beat with no prediction waiting");
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("popped_valid", want.popped_valid, out_data.popped_valid);
          check_field("popped_tag", want.popped_tag, out_data.popped_tag);
          check_field("popped_stamp", want.popped_stamp, out_data.popped_stamp);
          check_field("popped_seq", want.popped_seq, out_data.popped_seq);
          check_field("head_tag", want.head_tag, out_data.head_tag);
          check_field("head_stamp", want.head_stamp, out_data.head_stamp);
          check_field("is_empty", want.is_empty, out_data.is_empty);
          check_field("occupancy", want.occupancy, out_data.occupancy);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    // pop on empty with junk key fields
    add_beat(MODE_POP, STAMP_MAX, SEQ_MAX, 16'hFFFF, 1'b0);
    // fill to the depth: extremes, equal keys, ties on stamp alone
    add_beat(MODE_PUSH, STAMP_MAX, SEQ_MAX, 16'hFFFF, 1'b0);
    add_beat(MODE_PUSH, '0, '0, 16'h0000, 1'b0);
    add_beat(MODE_PUSH, 64'd5, 32'd7, 16'h0001, 1'b0);
    add_beat(MODE_PUSH, 64'd5, 32'd7, 16'h0002, 1'b0);
    add_beat(MODE_PUSH, 64'd5, 32'd7, 16'h0003, 1'b0);
    add_beat(MODE_PUSH, 64'd5, 32'd6, 16'h0004, 1'b0);
    add_beat(MODE_PUSH, 64'd5, 32'd8, 16'h0005, 1'b0);
    add_beat(MODE_PUSH, STAMP_MAX, SEQ_MAX, 16'h0006, 1'b0);
    add_beat(MODE_PUSH, '0, '0, 16'h0007, 1'b0);
    add_beat(MODE_PUSH, STAMP_MAX - 64'd1, '0, 16'h0008, 1'b0);
    add_beat(MODE_PUSH, 64'd1, SEQ_MAX, 16'h0009, 1'b0);
    add_beat(MODE_PUSH, '0, 32'd1, 16'h000A, 1'b0);
    add_beat(MODE_PUSH, 64'd5, 32'd7, 16'h000B, 1'b0);
    add_beat(MODE_PUSH, 64'h8000_0000_0000_0000, 32'h8000_0000, 16'h8000, 1'b0);
    add_beat(MODE_PUSH, 64'h0000_0001_0000_0000, '0, 16'h000C, 1'b0);
    add_beat(MODE_PUSH, 64'd2, 32'd2, 16'h000D, 1'b0);
    // push into a full queue
    add_beat(MODE_PUSH, '0, '0, 16'h000E, 1'b0);
    add_beat(MODE_POP, '0, '0, '0, 1'b0);
    add_beat(MODE_POP, '0, '0, '0, 1'b0);
    add_beat(MODE_POP, '0, '0, '0, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // no idling, then sender idle, receiver stall, both lightly
    add_random(340);
    while (beats_to_send.size() > 0) @(negedge clk);
    send_idle  = 53;
    recv_stall = 0;
    add_random(330);
    while (beats_to_send.size() > 0) @(negedge clk);
    send_idle  = 0;
    recv_stall = 53;
    add_random(330);
    while (beats_to_send.size() > 0) @(negedge clk);
    send_idle  = 13;
    recv_stall = 13;
    add_random(330);

    // drain, then wait for stray beats
    while (beats_to_send.size() > 0 || in_valid || awaited_results.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0)
      $display("[timestamp_ordered_event_queue] OK");
    else
      $display("[timestamp_ordered_event_queue] ERROR");
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #(400_000 * 12);
    $display("[timestamp_ordered_event_queue] ERROR");
    $finish;
  end

endmodule
